FILE: sv/hs_pkg.sv
package hs_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int DIGEST_BYTES = 20;
  localparam int KEY_CNT_W    = $clog2(BLOCK_BYTES + 1);
  localparam int KEY_IDX_W    = $clog2(BLOCK_BYTES);

  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5c;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [3:0] {
    S_KEY, S_MSG, S_LCOPY, S_LPEND, S_IPAD, S_FIN, S_KSTORE, S_OPAD, S_DIG, S_OUT
  } seq_t;

  typedef enum logic [1:0] {CTX_KEY, CTX_INNER, CTX_OUTER} ctx_t;

  typedef enum logic [1:0] {F_MARK, F_ZERO, F_LEN, F_DONE} fin_t;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_st_t;

  typedef struct packed {
    logic       init;
    logic       valid;
    logic [7:0] data;
    logic       count;
  } feed_t;

  typedef struct packed {
    logic        ready;
    logic [5:0]  fill;
    logic [63:0] bit_len;
  } core_stat_t;

  // Byte sel of a word, big-endian: sel 0 is the top byte.
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [31:0] s;
    s = w >> {~sel, 3'b000};
    return s[7:0];
  endfunction

endpackage

FILE: sv/hs_core.sv
module hs_core
  import hs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  feed_t            feed,
  output core_stat_t       stat,
  output logic [4:0][31:0] chain
);

  core_st_t          st;
  logic [6:0]        round;
  logic [5:0]        fill;
  logic [63:0]       bit_len;
  logic [4:0][31:0]  h;
  logic [31:0]       w [16];
  logic [23:0]       acc;
  logic [31:0]       a, b, c, d, e;

  logic [31:0] f, k, t, w_new, x;

  always_comb begin
    priority if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    // The window holds W[t] to W[t+15]; this is W[t+16].
    x = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {x[30:0], x[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= C_IDLE;
      round   <= '0;
      fill    <= '0;
      bit_len <= '0;
      h       <= SHA1_IV;
    end else begin
      unique case (st)
        C_IDLE: begin
          if (feed.init) begin
            h       <= SHA1_IV;
            fill    <= '0;
            bit_len <= '0;
          end else if (feed.valid) begin
            fill <= fill + 6'd1;
            if (feed.count) bit_len <= bit_len + 64'd8;
            if (fill == 6'd63) begin
              st    <= C_ROUND;
              round <= '0;
            end
          end
        end
        C_ROUND: begin
          round <= round + 7'd1;
          if (round == 7'd79) st <= C_ADD;
        end
        C_ADD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          st   <= C_IDLE;
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == C_IDLE && !feed.init && feed.valid) begin
      acc <= {acc[15:0], feed.data};
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= {acc, feed.data};
      end
      if (fill == 6'd63) begin
        a <= h[0];
        b <= h[1];
        c <= h[2];
        d <= h[3];
        e <= h[4];
      end
    end else if (st == C_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign stat.ready   = (st == C_IDLE);
  assign stat.fill    = fill;
  assign stat.bit_len = bit_len;
  assign chain        = h;

endmodule

FILE: sv/hmac_sha1_engine.sv
// HMAC-SHA1 engine.
// Input channel (in_valid/in_ready): one beat per key or message byte. op = 0
// marks key beats, op = 1 message beats; last ends each part, and a beat with
// has_byte = 0 carries no byte (so a part may be empty). Beats for the wrong
// part are taken and dropped.
// Output channel (out_valid/out_ready): after the last message beat, five
// beats carry the digest words, word_index 0 to 4, last_word on the fifth.
// Throughput: key beats up to 64 bytes take one cycle each. Hashed bytes take
// one cycle each, and every full 64-byte block then holds the input while the
// shared SHA-1 round unit runs (one round per cycle, then the final add). Key
// bytes live in a 64-byte memory with one write and one read port; each pad
// byte is read from it before it is fed to the hash, one byte at a time.
// A key longer than 64 bytes first has its stored block loaded into the hash,
// and after its last beat it is padded and its 20-byte digest is stored as the
// new key.
// While the digest words wait on out_ready, no input is taken. Reset returns
// the block to awaiting a key, with an empty key and a fresh hash state.
module hmac_sha1_engine
  import hs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  seq_t                 state, state_next;
  ctx_t                 ctx, ctx_next;
  fin_t                 fstep, fstep_next;
  logic [6:0]           cnt, cnt_next;
  logic                 fetched, fetched_next;
  logic                 started, started_next;
  logic [KEY_CNT_W-1:0] key_count, key_count_next;
  logic                 key_long, key_long_next;
  logic [7:0]           pend_byte, pend_byte_next;
  logic                 pend_last, pend_last_next;
  logic [2:0]           widx, widx_next;
  logic [4:0][31:0]     inner, inner_next;

  logic [7:0]           key_mem [BLOCK_BYTES];
  logic [7:0]           rdata;
  logic                 mem_we, mem_re;
  logic [KEY_IDX_W-1:0] mem_waddr;
  logic [7:0]           mem_wdata;

  feed_t            feed;
  core_stat_t       cstat;
  logic [4:0][31:0] chain;

  logic       accept;
  logic [7:0] key_byte;
  logic [7:0] pad;

  hs_core u_core (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .stat  (cstat),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (mem_we) key_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= key_mem[cnt[KEY_IDX_W-1:0]];
  end

  assign in_ready = (state == S_KEY || state == S_MSG) && cstat.ready;
  assign accept   = in_valid && in_ready;
  // Entries at or past the key length read as zero, so no clearing is needed.
  assign key_byte = (cnt < 7'(key_count)) ? rdata : 8'h00;
  assign pad      = (state == S_IPAD) ? IPAD : OPAD;

  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 3'd4);

  always_comb begin
    state_next     = state;
    ctx_next       = ctx;
    fstep_next     = fstep;
    cnt_next       = cnt;
    fetched_next   = fetched;
    started_next   = started;
    key_count_next = key_count;
    key_long_next  = key_long;
    pend_byte_next = pend_byte;
    pend_last_next = pend_last;
    widx_next      = widx;
    inner_next     = inner;
    feed           = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = key_count[KEY_IDX_W-1:0];
    mem_wdata      = data_byte;

    unique case (state)
      S_KEY: begin
        if (accept && !op) begin
          if (has_byte && !key_long && key_count == KEY_CNT_W'(BLOCK_BYTES)) begin
            // The key outgrows one block: hash the stored block, then this byte.
            key_long_next  = 1'b1;
            pend_byte_next = data_byte;
            pend_last_next = last;
            cnt_next       = '0;
            started_next   = 1'b0;
            fetched_next   = 1'b0;
            state_next     = S_LCOPY;
          end else begin
            if (has_byte) begin
              if (key_long) begin
                feed.valid = 1'b1;
                feed.data  = data_byte;
                feed.count = 1'b1;
              end else begin
                mem_we         = 1'b1;
                key_count_next = key_count + KEY_CNT_W'(1);
              end
            end
            if (last) begin
              cnt_next     = '0;
              started_next = 1'b0;
              fetched_next = 1'b0;
              fstep_next   = F_MARK;
              ctx_next     = CTX_KEY;
              state_next   = key_long ? S_FIN : S_IPAD;
            end
          end
        end
      end

      S_MSG: begin
        if (accept && op) begin
          if (has_byte) begin
            feed.valid = 1'b1;
            feed.data  = data_byte;
            feed.count = 1'b1;
          end
          if (last) begin
            fstep_next = F_MARK;
            ctx_next   = CTX_INNER;
            state_next = S_FIN;
          end
        end
      end

      S_LCOPY, S_IPAD, S_OPAD: begin
        if (!started) begin
          if (cstat.ready) begin
            feed.init    = 1'b1;
            started_next = 1'b1;
          end
        end else if (!fetched) begin
          mem_re       = 1'b1;
          fetched_next = 1'b1;
        end else if (cstat.ready) begin
          feed.valid   = 1'b1;
          feed.count   = 1'b1;
          feed.data    = (state == S_LCOPY) ? rdata : (key_byte ^ pad);
          fetched_next = 1'b0;
          cnt_next     = cnt + 7'd1;
          if (cnt == 7'(BLOCK_BYTES - 1)) begin
            cnt_next = '0;
            unique case (state)
              S_LCOPY: state_next = S_LPEND;
              S_IPAD:  state_next = S_MSG;
              default: state_next = S_DIG;
            endcase
          end
        end
      end

      S_LPEND: begin
        if (cstat.ready) begin
          feed.valid = 1'b1;
          feed.data  = pend_byte;
          feed.count = 1'b1;
          fstep_next = F_MARK;
          ctx_next   = CTX_KEY;
          state_next = pend_last ? S_FIN : S_KEY;
        end
      end

      S_FIN: begin
        if (cstat.ready) begin
          unique case (fstep)
            F_MARK: begin
              feed.valid = 1'b1;
              feed.data  = PAD_MARK;
              fstep_next = F_ZERO;
            end
            F_ZERO: begin
              if (cstat.fill == 6'd56) begin
                cnt_next   = '0;
                fstep_next = F_LEN;
              end else begin
                feed.valid = 1'b1;
              end
            end
            F_LEN: begin
              feed.valid = 1'b1;
              feed.data  = 8'(cstat.bit_len >> {~cnt[2:0], 3'b000});
              cnt_next   = cnt + 7'd1;
              if (cnt[2:0] == 3'd7) fstep_next = F_DONE;
            end
            default: begin
              cnt_next     = '0;
              started_next = 1'b0;
              fetched_next = 1'b0;
              unique case (ctx)
                CTX_KEY:   state_next = S_KSTORE;
                CTX_INNER: begin
                  inner_next = chain;
                  state_next = S_OPAD;
                end
                default: begin
                  widx_next  = '0;
                  state_next = S_OUT;
                end
              endcase
            end
          endcase
        end
      end

      S_KSTORE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[KEY_IDX_W-1:0];
        mem_wdata = word_byte(chain[cnt[4:2]], cnt[1:0]);
        cnt_next  = cnt + 7'd1;
        if (cnt == 7'(DIGEST_BYTES - 1)) begin
          key_count_next = KEY_CNT_W'(DIGEST_BYTES);
          cnt_next       = '0;
          started_next   = 1'b0;
          fetched_next   = 1'b0;
          state_next     = S_IPAD;
        end
      end

      S_DIG: begin
        if (cstat.ready) begin
          feed.valid = 1'b1;
          feed.count = 1'b1;
          feed.data  = word_byte(inner[cnt[4:2]], cnt[1:0]);
          cnt_next   = cnt + 7'd1;
          if (cnt == 7'(DIGEST_BYTES - 1)) begin
            fstep_next = F_MARK;
            ctx_next   = CTX_OUTER;
            state_next = S_FIN;
          end
        end
      end

      S_OUT: begin
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd4) begin
            feed.init      = 1'b1;
            key_count_next = '0;
            key_long_next  = 1'b0;
            state_next     = S_KEY;
          end
        end
      end

      default: state_next = S_KEY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_KEY;
      ctx       <= CTX_KEY;
      fstep     <= F_MARK;
      cnt       <= '0;
      fetched   <= 1'b0;
      started   <= 1'b0;
      key_count <= '0;
      key_long  <= 1'b0;
      widx      <= '0;
    end else begin
      state     <= state_next;
      ctx       <= ctx_next;
      fstep     <= fstep_next;
      cnt       <= cnt_next;
      fetched   <= fetched_next;
      started   <= started_next;
      key_count <= key_count_next;
      key_long  <= key_long_next;
      widx      <= widx_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    pend_last <= pend_last_next;
    inner     <= inner_next;
  end

`ifndef SYNTHESIS
  a_feed_when_ready: assert property (@(posedge clk) disable iff (rst)
    (feed.valid || feed.init) |-> cstat.ready)
    else $error("byte or init sent to the SHA-1 unit while it is busy");

  a_key_count_max: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEY_CNT_W'(BLOCK_BYTES))
    else $error("key length above one block");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while digest words are pending");

  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (widx <= 3'd4))
    else $error("digest word index out of range");
`endif

endmodule

FILE: dv/tb_hmac_sha1_engine.sv
module tb_hmac_sha1_engine;
  import hs_pkg::*;

  localparam bit OP_KEY = 1'b0;
  localparam bit OP_MSG = 1'b1;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  hmac_sha1_engine dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .data_byte(data_byte), .has_byte(has_byte), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .digest_word(digest_word), .word_index(word_index),
    .last_word(last_word)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_beat_t;

  // Predictor state.
  logic [7:0]  p_key [BLOCK_BYTES];
  int          p_key_len;
  bit          p_key_long;
  logic [31:0] p_h [5];
  logic [31:0] p_w [16];
  int          p_fill;
  logic [63:0] p_bits;
  bit          p_in_msg;

  digest_beat_t expected_words[$];
  int errors;
  int idle_cycles;
  int beats_sent;
  int digests_seen;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = p_w[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = p_h[0]; b = p_h[1]; c = p_h[2]; d = p_h[3]; e = p_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    p_h[0] += a; p_h[1] += b; p_h[2] += c; p_h[3] += d; p_h[4] += e;
  endfunction

  function automatic void sha_start();
    for (int i = 0; i < 5; i++) p_h[i] = SHA1_IV[i];
    p_fill = 0;
    p_bits = '0;
  endfunction

  function automatic void sha_put(input logic [7:0] v);
    int sh;
    sh = (3 - (p_fill % 4)) * 8;
    if (p_fill % 4 == 0) p_w[p_fill / 4] = 32'(v) << 24;
    else p_w[p_fill / 4] |= 32'(v) << sh;
    p_fill++;
    if (p_fill == 64) begin
      sha_block();
      p_fill = 0;
    end
  endfunction

  function automatic void sha_absorb(input logic [7:0] v);
    sha_put(v);
    p_bits += 64'd8;
  endfunction

  function automatic void sha_close(output logic [31:0] dg [5]);
    logic [63:0] len;
    len = p_bits;
    sha_put(PAD_MARK);
    while (p_fill != 56) sha_put(8'h00);
    for (int i = 0; i < 8; i++) sha_put(len[63 - 8*i -: 8]);
    for (int i = 0; i < 5; i++) dg[i] = p_h[i];
  endfunction

  function automatic void key_clear();
    for (int i = 0; i < BLOCK_BYTES; i++) p_key[i] = 8'h00;
    p_key_len = 0;
    p_key_long = 0;
  endfunction

  // Advances the HMAC predictor by one accepted beat and queues any digest words.
  function automatic void hmac_predict(input bit o, input logic [7:0] b, input bit hb,
                                       input bit lst);
    logic [31:0] dg [5];
    logic [31:0] inner [5];
    if (!p_in_msg) begin
      if (o != OP_KEY) return;
      if (hb) begin
        if (p_key_long) sha_absorb(b);
        else if (p_key_len < BLOCK_BYTES) begin
          p_key[p_key_len] = b;
          p_key_len++;
        end else begin
          p_key_long = 1;
          sha_start();
          for (int i = 0; i < BLOCK_BYTES; i++) sha_absorb(p_key[i]);
          sha_absorb(b);
        end
      end
      if (lst) begin
        if (p_key_long) begin
          sha_close(dg);
          for (int i = 0; i < BLOCK_BYTES; i++) p_key[i] = 8'h00;
          for (int i = 0; i < DIGEST_BYTES; i++) p_key[i] = dg[i/4][31 - 8*(i%4) -: 8];
        end
        sha_start();
        for (int i = 0; i < BLOCK_BYTES; i++) sha_absorb(p_key[i] ^ IPAD);
        p_in_msg = 1;
      end
      return;
    end
    if (o != OP_MSG) return;
    if (hb) sha_absorb(b);
    if (!lst) return;
    sha_close(inner);
    sha_start();
    for (int i = 0; i < BLOCK_BYTES; i++) sha_absorb(p_key[i] ^ OPAD);
    for (int i = 0; i < DIGEST_BYTES; i++) sha_absorb(inner[i/4][31 - 8*(i%4) -: 8]);
    sha_close(dg);
    for (int i = 0; i < 5; i++)
      expected_words.push_back('{word: dg[i], index: 3'(i), final_word: (i == 4)});
    key_clear();
    sha_start();
    p_in_msg = 0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high from one beat to the next when there is no gap.
  task automatic send_beat(input bit o, input logic [7:0] b, input bit hb, input bit lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    data_byte <= b;
    has_byte  <= hb;
    last      <= lst;
    do @(posedge clk); while (!in_ready);
    hmac_predict(o, b, hb, lst);
    beats_sent++;
  endtask

  task automatic send_key(input int len);
    if (len == 0) send_beat(OP_KEY, 8'($urandom), 1'b0, 1'b1);
    for (int i = 0; i < len; i++) send_beat(OP_KEY, 8'($urandom), 1'b1, i == len - 1);
  endtask

  task automatic send_msg(input int len);
    if (len == 0) send_beat(OP_MSG, 8'($urandom), 1'b0, 1'b1);
    for (int i = 0; i < len; i++) send_beat(OP_MSG, 8'($urandom), 1'b1, i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Extreme bytes, empty key and message, wrong-part beats and byteless beats.
  task automatic test_directed();
    send_beat(OP_MSG, 8'hFF, 1'b1, 1'b1);
    send_beat(OP_KEY, 8'h00, 1'b1, 1'b0);
    send_beat(OP_KEY, 8'hAA, 1'b0, 1'b0);
    send_beat(OP_KEY, 8'hFF, 1'b1, 1'b1);
    send_beat(OP_KEY, 8'h55, 1'b1, 1'b1);
    send_beat(OP_MSG, 8'h00, 1'b1, 1'b0);
    send_beat(OP_MSG, 8'h3C, 1'b0, 1'b0);
    send_beat(OP_MSG, 8'hFF, 1'b1, 1'b1);
    send_beat(OP_KEY, 8'h00, 1'b0, 1'b1);
    send_beat(OP_MSG, 8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  // A key one byte over a block, and a message whose padding spills into a second block.
  task automatic test_block_edges();
    send_key(BLOCK_BYTES + 1);
    send_msg(56);
    wait_drained();
  endtask

  task automatic test_random();
    int r, klen, mlen;
    while (beats_sent < 150) begin
      r = $urandom_range(0, 99);
      if (r < 15) klen = 0;
      else klen = $urandom_range(1, 8);
      send_key(klen);
      if ($urandom_range(0, 9) == 0)
        send_beat(OP_KEY, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 15) mlen = 0;
      else mlen = $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) send_beat(OP_MSG, 8'($urandom), 1'b0, 1'b0);
      send_msg(mlen);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 99) < 60) out_ready <= 1'b1;
    else if ($urandom_range(0, 99) < 90) out_ready <= 1'b0;
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("digest beat with nothing expected: word %h", digest_word);
        errors++;
      end else begin
        exp_b = expected_words.pop_front();
        if (digest_word !== exp_b.word) begin
          $error("digest_word expected %h actual %h", exp_b.word, digest_word);
          errors++;
        end
        if (word_index !== exp_b.index) begin
          $error("word_index expected %0d actual %0d", exp_b.index, word_index);
          errors++;
        end
        if (last_word !== exp_b.final_word) begin
          $error("last_word expected %0d actual %0d", exp_b.final_word, last_word);
          errors++;
        end
        if (exp_b.final_word) digests_seen++;
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = 1'b0;
    data_byte = 8'h00;
    has_byte = 1'b0;
    last = 1'b0;
    errors = 0;
    idle_cycles = 0;
    beats_sent = 0;
    digests_seen = 0;
    p_in_msg = 0;
    key_clear();
    sha_start();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_block_edges();
    test_random();
    repeat (50) @(posedge clk);
    $display("Sent %0d input beats and checked %0d HMAC digests, covering empty,",
             beats_sent, digests_seen);
    $display("short and hashed long keys plus dropped and byteless beats.");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/hs_pkg.sv
sv/hs_core.sv
sv/hmac_sha1_engine.sv
dv/tb_hmac_sha1_engine.sv
